// ===== rtl/core/aabbcet_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabbcet_pkg
// Shared types, widths and event codes for the contact event tracker.
// ----------------------------------------------------------------------------
package aabbcet_pkg;

    localparam int ID_BITS = 6;
    localparam int ROW_W   = 1 << ID_BITS;   // contact bits per row (one per right id)
    localparam int N_ROWS  = 1 << ID_BITS;   // one row per left id
    localparam int COORD_W = 16;

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [1:0]         t_event;

    localparam t_event EV_NONE  = 2'd0;
    localparam t_event EV_ENTER = 2'd1;
    localparam t_event EV_STAY  = 2'd2;
    localparam t_event EV_EXIT  = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        t_id  row;
        t_row wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== rtl/core/aabbcet_overlap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabbcet_overlap
// Registered two-axis box overlap test in Q12.4 fixed point.
// ----------------------------------------------------------------------------
module aabbcet_overlap (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_left_x,
    input  wire logic [15:0] i_left_y,
    input  wire logic [15:0] i_left_w,
    input  wire logic [15:0] i_left_h,
    input  wire logic [15:0] i_right_x,
    input  wire logic [15:0] i_right_y,
    input  wire logic [15:0] i_right_w,
    input  wire logic [15:0] i_right_h,
    output logic             o_overlap
);
    import aabbcet_pkg::*;

    logic r_ov;
    logic n_ov;

    // 2*|pa-pb| < sa+sb, all exact in 17 bits
    function automatic logic axis_hit(input logic [COORD_W-1:0] pa,
                                      input logic [COORD_W-1:0] pb,
                                      input logic [COORD_W-1:0] sa,
                                      input logic [COORD_W-1:0] sb);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] mag;
        logic        [COORD_W:0] sum;
        d   = $signed({pa[COORD_W-1], pa}) - $signed({pb[COORD_W-1], pb});
        mag = d[COORD_W] ? -d : d;
        sum = {1'b0, sa} + {1'b0, sb};
        return {mag[COORD_W-1:0], 1'b0} < sum;
    endfunction

    assign n_ov = axis_hit(i_left_x, i_right_x, i_left_w, i_right_w) &&
                  axis_hit(i_left_y, i_right_y, i_left_h, i_right_h);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ov <= n_ov;
        end
    end

    assign o_overlap = r_ov;

endmodule
`default_nettype wire

// ===== rtl/core/aabbcet_contact_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabbcet_contact_mem
// Contact bit store: one row per left id, registered read, with a
// per-row valid bit so that rows never written read as all zero.
// ----------------------------------------------------------------------------
module aabbcet_contact_mem (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire aabbcet_pkg::t_mem_req i_req,
    output aabbcet_pkg::t_row          o_rd_data
);
    import aabbcet_pkg::*;

    t_row              r_mem [N_ROWS];
    t_row              r_rd_data;
    logic [N_ROWS-1:0] r_row_valid;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.row] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_row_valid[i_req.row];
            end
            if (i_req.wr_en) begin
                r_row_valid[i_req.row] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== rtl/core/aabb_contact_event_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker_unit
// Box overlap test with enter / stay / exit tracking per ordered id pair.
// ----------------------------------------------------------------------------
// A pair word is taken at a clock edge where start is high and busy is low.
// Its result word appears on o_event_res / o_overlapping for exactly one
// cycle, marked by o_valid, after the word has passed states RD and WB; the
// receiver cannot hold it off, so capture it when o_valid is high. The unit
// takes no new word until done with the last: RD reads the contact row of
// the left id from the single-port contact memory (the overlap test runs in
// the same cycle), WB updates the pair's bit and writes the row back, then
// busy drops. The next start may coincide with o_valid of the previous word.
// The contact memory needs no clearing after reset: a valid bit per row
// makes unwritten rows read as "no contact", so the unit is ready right
// after reset. Ids that are equal give event none and leave the memory alone.
// ----------------------------------------------------------------------------
module aabb_contact_event_tracker_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire aabbcet_pkg::t_id    i_left_id,
    input  wire aabbcet_pkg::t_id    i_right_id,
    input  wire logic signed [15:0]  i_left_x,
    input  wire logic signed [15:0]  i_left_y,
    input  wire logic        [15:0]  i_left_w,
    input  wire logic        [15:0]  i_left_h,
    input  wire logic signed [15:0]  i_right_x,
    input  wire logic signed [15:0]  i_right_y,
    input  wire logic        [15:0]  i_right_w,
    input  wire logic        [15:0]  i_right_h,
    input  wire logic                i_left_dead,
    input  wire logic                i_right_dead,
    output logic                     o_valid,
    output aabbcet_pkg::t_event      o_event_res,
    output logic                     o_overlapping
);
    import aabbcet_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;   // row read issued, overlap computed
    localparam logic [1:0] ST_WB   = 2'd2;   // row back, event decided, write back

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // captured pair word
    t_id         r_lid;
    t_id         r_rid;
    logic [15:0] r_lx, r_ly, r_lw, r_lh;
    logic [15:0] r_rx, r_ry, r_rw, r_rh;
    logic        r_dead;

    // result word
    logic   r_valid;
    t_event r_event;
    logic   r_ov_out;

    logic     ov;
    t_row     rd_row;
    t_row     n_row;
    t_mem_req mem_req;
    logic     same_id;
    logic     prev;
    logic     next;
    t_event   n_event;

    assign accept  = start && (r_state == ST_IDLE);
    assign busy    = (r_state != ST_IDLE);
    assign same_id = (r_lid == r_rid);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_RD;
            end
            ST_RD:   n_state = ST_WB;
            ST_WB:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_WB);
        end
    end

    // hold the pair word for the whole update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lid  <= i_left_id;
            r_rid  <= i_right_id;
            r_lx   <= i_left_x;
            r_ly   <= i_left_y;
            r_lw   <= i_left_w;
            r_lh   <= i_left_h;
            r_rx   <= i_right_x;
            r_ry   <= i_right_y;
            r_rw   <= i_right_w;
            r_rh   <= i_right_h;
            r_dead <= i_left_dead | i_right_dead;
        end
    end

    aabbcet_overlap u_overlap (
        .i_clk     (i_clk),
        .i_en      (r_state == ST_RD),
        .i_left_x  (r_lx),
        .i_left_y  (r_ly),
        .i_left_w  (r_lw),
        .i_left_h  (r_lh),
        .i_right_x (r_rx),
        .i_right_y (r_ry),
        .i_right_w (r_rw),
        .i_right_h (r_rh),
        .o_overlap (ov)
    );

    // event decision on the returned row
    always_comb begin
        prev    = rd_row[r_rid];
        next    = 1'b0;
        n_event = EV_NONE;
        if (!same_id) begin
            if (ov && !r_dead) begin
                n_event = prev ? EV_STAY : EV_ENTER;
                next    = 1'b1;
            end else if (prev) begin
                n_event = EV_EXIT;
            end
        end
        n_row        = rd_row;
        n_row[r_rid] = next;
    end

    // read in RD, write back in WB; equal ids never write the store
    always_comb begin
        mem_req.rd_en = (r_state == ST_RD);
        mem_req.wr_en = (r_state == ST_WB) && !same_id;
        mem_req.row   = r_lid;
        mem_req.wdata = n_row;
    end

    aabbcet_contact_mem u_contact_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            r_event  <= n_event;
            r_ov_out <= ov;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_res   = r_event;
    assign o_overlapping = r_ov_out;

    // a result strobe always follows a write-back cycle
    a_valid_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_WB)
        else $error("result strobe without write-back cycle");

    // enter and stay only ever report overlapping boxes
    a_enter_stay_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_ENTER || o_event_res == EV_STAY) |-> o_overlapping)
        else $error("enter/stay without overlap");

    // an accepted word produces a result strobe after states RD and WB
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##2 o_valid)
        else $error("missing result for accepted word");

    // the contact store is never written for a pair with equal ids
    a_no_self_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> !same_id)
        else $error("contact write for equal ids");

endmodule
`default_nettype wire

// ===== verif/aabb_contact_event_tracker_unit_test.sv =====
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker_unit_test
// Self-checking bench for the box contact event tracker. Feeds pair words
// through the start/busy handshake and keeps its own copy of the per-pair
// contact table. Each result word is compared with the oldest expected one.
// Stimulus runs directed edge cases, event sequences and equal ids first,
// then random traffic biased toward few id pairs, with varied sender gaps.
// ----------------------------------------------------------------------------
module aabb_contact_event_tracker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aabbcet_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 10;
    localparam int DRAIN_GUARD  = 1000;
    localparam int MAP_DEPTH    = 1 << (2 * ID_BITS);

    // One pair word as the sender drives it.
    typedef struct {
        t_id               lid;
        t_id               rid;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic        [15:0] lw;
        logic        [15:0] lh;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic        [15:0] rw;
        logic        [15:0] rh;
        logic               ldead;
        logic               rdead;
    } t_pair;

    // One result word as the tracker should report it.
    typedef struct {
        t_event code;
        logic   hit;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_id                i_left_id;
    t_id                i_right_id;
    logic signed [15:0] i_left_x;
    logic signed [15:0] i_left_y;
    logic        [15:0] i_left_w;
    logic        [15:0] i_left_h;
    logic signed [15:0] i_right_x;
    logic signed [15:0] i_right_y;
    logic        [15:0] i_right_w;
    logic        [15:0] i_right_h;
    logic               i_left_dead;
    logic               i_right_dead;
    logic               o_valid;
    t_event             o_event_res;
    logic               o_overlapping;

    // Bench copy of the contact table, indexed by {left id, right id}.
    bit       contact_map [MAP_DEPTH];
    t_outcome pending_outcomes [$];
    int       mismatch_count;

    aabb_contact_event_tracker_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_left_id     (i_left_id),
        .i_right_id    (i_right_id),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_left_w      (i_left_w),
        .i_left_h      (i_left_h),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_right_w     (i_right_w),
        .i_right_h     (i_right_h),
        .i_left_dead   (i_left_dead),
        .i_right_dead  (i_right_dead),
        .o_valid       (o_valid),
        .o_event_res   (o_event_res),
        .o_overlapping (o_overlapping)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Strict overlap on one axis: 2*|pa-pb| < sa+sb, computed wide enough
    // that neither the difference nor the size sum can wrap.
    function automatic bit axis_hit(logic signed [15:0] pa, logic signed [15:0] pb,
                                    logic [15:0] sa, logic [15:0] sb);
        int delta;
        int reach;
        delta = int'(pa) - int'(pb);
        reach = int'(sa) + int'(sb);
        if (delta < 0) begin
            delta = -delta;
        end
        return (2 * delta) < reach;
    endfunction

    // Work out the event for one accepted pair word and advance the table.
    function automatic t_outcome track_contact(t_pair p);
        t_outcome res;
        int       slot;
        bit       was_in;
        res.hit  = axis_hit(p.lx, p.rx, p.lw, p.rw) && axis_hit(p.ly, p.ry, p.lh, p.rh);
        res.code = EV_NONE;
        // Equal ids never touch the table and always report none.
        if (p.lid != p.rid) begin
            slot   = int'({p.lid, p.rid});
            was_in = contact_map[slot];
            if (res.hit && !(p.ldead || p.rdead)) begin
                res.code          = was_in ? EV_STAY : EV_ENTER;
                contact_map[slot] = 1'b1;
            end else begin
                // A dead collider breaks contact even while the boxes overlap.
                if (was_in) begin
                    res.code = EV_EXIT;
                end
                contact_map[slot] = 1'b0;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking: sample at the falling edge, where the strobe and the result
    // word are settled for the whole cycle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with nothing expected: event_res %0d overlapping %0b",
                       o_event_res, o_overlapping);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_event_res !== want.code) begin
                    $error("event_res mismatch: expected %0d, actual %0d",
                           want.code, o_event_res);
                    mismatch_count++;
                end
                if (o_overlapping !== want.hit) begin
                    $error("overlapping mismatch: expected %0b, actual %0b",
                           want.hit, o_overlapping);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Drive one pair word and hold it until the tracker takes it. Call at a
    // rising edge; return at the accepting edge with start still high, so a
    // following word can go out on that same edge without a glitch on start.
    task automatic send_pair(t_pair p);
        bit taken;
        i_left_id    <= p.lid;
        i_right_id   <= p.rid;
        i_left_x     <= p.lx;
        i_left_y     <= p.ly;
        i_left_w     <= p.lw;
        i_left_h     <= p.lh;
        i_right_x    <= p.rx;
        i_right_y    <= p.ry;
        i_right_w    <= p.rw;
        i_right_h    <= p.rh;
        i_left_dead  <= p.ldead;
        i_right_dead <= p.rdead;
        start        <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            // busy is settled here; if low, the next rising edge takes the word.
            if (!busy) begin
                pending_outcomes.push_back(track_contact(p));
                taken = 1'b1;
            end
            @(posedge i_clk);
        end
    endtask

    // Drop start for a while and scramble the payload, which must be ignored.
    task automatic hold_off(int cycles);
        start        <= 1'b0;
        i_left_id    <= t_id'($urandom);
        i_right_id   <= t_id'($urandom);
        i_left_x     <= 16'($urandom);
        i_left_y     <= 16'($urandom);
        i_left_w     <= 16'($urandom);
        i_left_h     <= 16'($urandom);
        i_right_x    <= 16'($urandom);
        i_right_y    <= 16'($urandom);
        i_right_w    <= 16'($urandom);
        i_right_h    <= 16'($urandom);
        i_left_dead  <= 1'($urandom);
        i_right_dead <= 1'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic t_pair build_pair(t_id lid, t_id rid,
                                         int lx, int ly, int lw, int lh,
                                         int rx, int ry, int rw, int rh,
                                         bit ldead, bit rdead);
        t_pair p;
        p.lid   = lid;
        p.rid   = rid;
        p.lx    = 16'(lx);
        p.ly    = 16'(ly);
        p.lw    = 16'(lw);
        p.lh    = 16'(lh);
        p.rx    = 16'(rx);
        p.ry    = 16'(ry);
        p.rw    = 16'(rw);
        p.rh    = 16'(rh);
        p.ldead = ldead;
        p.rdead = rdead;
        return p;
    endfunction

    // Two 20x20 boxes, left one at the origin, right one offset by (dx, dy).
    function automatic t_pair box_pair(t_id lid, t_id rid, int dx, int dy,
                                       bit ldead, bit rdead);
        return build_pair(lid, rid, 0, 0, 320, 320, dx, dy, 320, 320, ldead, rdead);
    endfunction

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Pick centers and sizes on one axis: mostly near misses and near hits,
    // some boxes exactly touching or one step in or out, the rest unconstrained.
    task automatic pick_axis(output logic signed [15:0] pa, output logic signed [15:0] pb,
                             output logic [15:0] sa, output logic [15:0] sb);
        int mode;
        int mid;
        int wa;
        int wb;
        int reach;
        int half;
        int gap;
        mode = $urandom_range(0, 99);
        mid  = span(-30000, 30000);
        if (mode < 55) begin
            wa    = span(0, 3000);
            wb    = span(0, 3000);
            reach = (wa + wb) * 3 / 4 + 20;
            pa    = 16'(mid);
            pb    = 16'(mid + span(-reach, reach));
            sa    = 16'(wa);
            sb    = 16'(wb);
        end else if (mode < 75) begin
            // Sizes sum to an even number so the boxes can touch exactly.
            half = span(0, 2000);
            wa   = span(0, 2 * half);
            gap  = half + span(-1, 1);
            pa   = 16'(mid);
            pb   = 16'($urandom_range(0, 1) ? mid + gap : mid - gap);
            sa   = 16'(wa);
            sb   = 16'(2 * half - wa);
        end else begin
            pa = 16'($urandom);
            pb = 16'($urandom);
            sa = 16'($urandom);
            sb = 16'($urandom);
        end
    endtask

    // Ids come mostly from a tiny pool so pairs revisit their contact bit and
    // walk through enter, stay and exit; the rest cover the full id range.
    task automatic pick_pair(output t_pair p);
        if ($urandom_range(0, 99) < 75) begin
            p.lid = t_id'($urandom_range(0, 3));
            p.rid = t_id'($urandom_range(0, 3));
        end else begin
            p.lid = t_id'($urandom);
            p.rid = t_id'($urandom);
        end
        pick_axis(p.lx, p.rx, p.lw, p.rw);
        pick_axis(p.ly, p.ry, p.lh, p.rh);
        p.ldead = ($urandom_range(0, 99) < 12);
        p.rdead = ($urandom_range(0, 99) < 12);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk one pair through every event, then its mirror pair on its own bit.
    task automatic test_event_sequences();
        send_pair(box_pair(1, 2, 100, -100, 1'b0, 1'b0));   // enter
        send_pair(box_pair(1, 2, 100, -100, 1'b0, 1'b0));   // stay
        send_pair(box_pair(1, 2, 5000, 0, 1'b0, 1'b0));     // exit, apart
        send_pair(box_pair(1, 2, 5000, 0, 1'b0, 1'b0));     // none, apart
        send_pair(box_pair(1, 2, -50, 60, 1'b0, 1'b0));     // enter again
        send_pair(box_pair(1, 2, -50, 60, 1'b1, 1'b0));     // exit, left dead
        send_pair(box_pair(1, 2, -50, 60, 1'b0, 1'b1));     // none, overlap but dead
        send_pair(box_pair(2, 1, 0, 0, 1'b0, 1'b0));        // enter, mirrored order
        send_pair(box_pair(2, 1, 0, 0, 1'b1, 1'b1));        // exit, both dead
    endtask

    // Equal ids report none but still report the true overlap.
    task automatic test_equal_ids();
        send_pair(box_pair(5, 5, 10, 10, 1'b0, 1'b0));
        send_pair(box_pair(5, 6, 10, 10, 1'b0, 1'b0));      // enter on a real pair
        send_pair(box_pair(5, 5, 9000, 0, 1'b0, 1'b0));
        send_pair(box_pair(63, 63, 0, 0, 1'b0, 1'b0));
    endtask

    // Strict compare at touching boxes, zero sizes and the coordinate extremes.
    task automatic test_overlap_edges();
        send_pair(build_pair(10, 11, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        send_pair(build_pair(10, 12, 0, 0, 16, 320, 16, 0, 16, 320, 1'b0, 1'b0));
        send_pair(build_pair(10, 12, 0, 0, 16, 320, 15, 0, 16, 320, 1'b0, 1'b0));
        send_pair(build_pair(10, 13, 0, 0, 320, 16, 0, -16, 320, 16, 1'b0, 1'b0));
        send_pair(build_pair(0, 63, -32768, 0, 65535, 65535, 32767, 0, 65535, 65535,
                             1'b0, 1'b0));
        send_pair(build_pair(63, 0, -32768, 0, 65535, 65535, 32766, 0, 65535, 65535,
                             1'b0, 1'b0));
        send_pair(build_pair(62, 1, 0, 32767, 1, 65535, 0, -32768, 1, 65535,
                             1'b0, 1'b0));
    endtask

    // Random pairs; idle_pct sets how often the sender pauses after a word.
    task automatic test_random_traffic(int idle_pct, int count);
        t_pair p;
        repeat (count) begin
            pick_pair(p);
            send_pair(p);
            if ($urandom_range(0, 99) < idle_pct) begin
                hold_off($urandom_range(1, 6));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int guard;
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_left_id      = '0;
        i_right_id     = '0;
        i_left_x       = '0;
        i_left_y       = '0;
        i_left_w       = '0;
        i_left_h       = '0;
        i_right_x      = '0;
        i_right_y      = '0;
        i_right_w      = '0;
        i_right_h      = '0;
        i_left_dead    = 1'b0;
        i_right_dead   = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words go back to back to overlap each start with the
        // previous result strobe.
        test_event_sequences();
        test_equal_ids();
        test_overlap_edges();
        hold_off(4);

        test_random_traffic(0, 350);
        test_random_traffic(74, 350);
        test_random_traffic(37, 350);
        hold_off(1);

        // Drain outstanding results, then allow a few cycles for strays.
        guard = 0;
        while (pending_outcomes.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_outcomes.size() != 0) begin
            $error("%0d expected result words never arrived", pending_outcomes.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("aabb_contact_event_tracker_unit regression: pass");
        end else begin
            $display("aabb_contact_event_tracker_unit regression: fail");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("aabb_contact_event_tracker_unit regression: fail");
        $finish;
    end

endmodule
